// File: design/led_matrix_bar_graph_scanner_assert.svh
// Assertion macros for the LED matrix bar graph scanner.
// Used by the RTL files that carry concurrent checks; no other dependencies.
`ifndef LED_MATRIX_BAR_GRAPH_SCANNER_ASSERT_SVH
`define LED_MATRIX_BAR_GRAPH_SCANNER_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, checked outside reset.
`define LMBG_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("check failed: lbl");

// Next-cycle implication, checked outside reset.
`define LMBG_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("check failed: lbl");

`else

`define LMBG_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define LMBG_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// File: design/lmbg_pkg.sv
// Shared types and constants of the LED matrix bar graph scanner.
// No dependencies; imported by the interfaces, the pixel compare unit, the top level and the testbench.
package lmbg_pkg;

  // Fixed field widths of the transaction payloads.
  localparam int unsigned OP_W     = 1;
  localparam int unsigned COL_W    = 6;
  localparam int unsigned LVL_IN_W = 8;
  localparam int unsigned ROW_W    = 5;
  localparam int unsigned ADDR_W   = 4;

  // Default sizes of the display.
  localparam int unsigned COLUMNS_DEF    = 64;
  localparam int unsigned HALF_ROWS_DEF  = 16;
  localparam int unsigned LEVEL_BITS_DEF = 8;

  // Item operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_LOAD = 1'b0,
    OP_SCAN = 1'b1
  } lmbg_op_e;

  // Active-low pin levels of one column, both halves.
  typedef struct packed {
    logic upper_red;
    logic upper_green;
    logic lower_red;
    logic lower_green;
  } lmbg_pins_t;

endpackage

// File: design/lmbg_if.sv
// Valid/ready channel interfaces for input items and scan results.
// Depends on lmbg_pkg for the field widths.
interface lmbg_item_if
  import lmbg_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     opcode;
  logic [COL_W-1:0]    column;
  logic [LVL_IN_W-1:0] bar_level;
  logic [LVL_IN_W-1:0] peak_level;
  logic [ROW_W-1:0]    row;

  modport source (output valid, opcode, column, bar_level, peak_level, row,
                  input ready);
  modport sink   (input valid, opcode, column, bar_level, peak_level, row,
                  output ready);
endinterface

interface lmbg_result_if
  import lmbg_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] row_address;
  logic [COL_W-1:0]  column_index;
  logic              upper_red;
  logic              upper_green;
  logic              lower_red;
  logic              lower_green;
  logic              last;

  modport source (output valid, row_address, column_index, upper_red, upper_green,
                  lower_red, lower_green, last, input ready);
  modport sink   (input valid, row_address, column_index, upper_red, upper_green,
                  lower_red, lower_green, last, output ready);
endinterface

// File: design/lmbg_level_ram.sv
// Column level memory: one write port, one read port with registered data.
// Depends on nothing but its parameters.
module lmbg_level_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/lmbg_pixel_cmp.sv
// Pixel compare unit: turns one column's levels and the scanned row into pin levels.
// Depends on lmbg_pkg for the pin struct.
module lmbg_pixel_cmp
  import lmbg_pkg::*;
#(
  parameter int unsigned LEVEL_BITS = LEVEL_BITS_DEF
) (
  input  logic [LEVEL_BITS-1:0] bar_i,
  input  logic [LEVEL_BITS-1:0] peak_i,
  input  logic [ROW_W-1:0]      row_i,
  input  logic                  upper_i,
  output lmbg_pins_t            pins_o
);

  // One bit of headroom so that row + 1 never wraps.
  localparam int unsigned CmpW = LEVEL_BITS + 1;

  logic [CmpW-1:0] bar_x;
  logic [CmpW-1:0] peak_x;
  logic [CmpW-1:0] row_x;
  logic [CmpW-1:0] row_inc;
  logic            red_lit;
  logic            green_lit;
  logic            red_pin;
  logic            green_pin;

  assign bar_x   = CmpW'(bar_i);
  assign peak_x  = CmpW'(peak_i);
  assign row_x   = CmpW'(row_i);
  assign row_inc = row_x + CmpW'(1);

  // The bar lights red above the row; the peak marker takes its row and the one below.
  assign red_lit   = bar_x > row_x;
  assign green_lit = (peak_x == row_x) || (peak_x == row_inc);
  assign red_pin   = ~(red_lit & ~green_lit);
  assign green_pin = ~green_lit;

  // Only the half holding the row is driven; the other half stays dark.
  always_comb begin
    pins_o = '{upper_red: 1'b1, upper_green: 1'b1, lower_red: 1'b1, lower_green: 1'b1};
    if (upper_i) begin
      pins_o.upper_red   = red_pin;
      pins_o.upper_green = green_pin;
    end else begin
      pins_o.lower_red   = red_pin;
      pins_o.lower_green = green_pin;
    end
  end

endmodule

// File: design/led_matrix_bar_graph_scanner.sv
// Top level of the LED matrix bar graph scanner: scan sequencer and output stage.
// Depends on lmbg_pkg, lmbg_if, lmbg_level_ram, lmbg_pixel_cmp and the assertion header.
//
//   port      | dir | transaction
//   ----------+-----+----------------------------------------------------
//   item_i    | in  | load one column's levels, or scan one display row
//   result_o  | out | row address, column index and pins of one column
//
// A scan reads one column per cycle from the level memory while the result
// port keeps up, COLUMNS reads in all, and each result passes through the memory
// read stage and the output register. The item port is held off from the scan's
// start until its last column has left the memory read stage. A stalled result
// port stops the reads; no result is dropped.
// Reset clears the control state only; the level memory is not cleared.
`include "led_matrix_bar_graph_scanner_assert.svh"

module led_matrix_bar_graph_scanner
  import lmbg_pkg::*;
#(
  parameter int unsigned COLUMNS    = COLUMNS_DEF,
  parameter int unsigned HALF_ROWS  = HALF_ROWS_DEF,
  parameter int unsigned LEVEL_BITS = LEVEL_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  lmbg_item_if.sink     item_i,
  lmbg_result_if.source result_o
);

  localparam int unsigned CntW  = $clog2(COLUMNS);
  localparam int unsigned WideW = 9;
  localparam int unsigned RowXW = 7;

  localparam logic [CntW-1:0]  LastCol   = CntW'(COLUMNS - 1);
  localparam logic [RowXW-1:0] HalfRowsX = RowXW'(HALF_ROWS);
  localparam logic [RowXW-1:0] LowerTop  = RowXW'(HALF_ROWS - 1);
  localparam logic [RowXW-1:0] UpperTop  = RowXW'(2 * HALF_ROWS - 1);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e              state_q, state_d;
  logic [CntW-1:0]     col_q, col_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic                upper_q, upper_d;
  logic [ADDR_W-1:0]   addr_q, addr_d;
  logic                s1_valid_q, s1_valid_d;
  logic [CntW-1:0]     s1_col_q, s1_col_d;
  logic                out_valid_q, out_valid_d;
  logic [ADDR_W-1:0]   out_addr_q, out_addr_d;
  logic [COL_W-1:0]    out_col_q, out_col_d;
  lmbg_pins_t          out_pins_q, out_pins_d;
  logic                out_last_q, out_last_d;

  logic                accept;
  logic                out_free;
  logic                s1_move;
  logic                issue;
  logic                ram_we;
  logic [WideW-1:0]    col_in_x;
  logic [WideW-1:0]    s1_col_x;
  logic [RowXW-1:0]    row_in_x;
  logic                upper_in;
  logic [RowXW-1:0]    addr_full;
  logic [2*LEVEL_BITS-1:0] ram_wdata;
  logic [2*LEVEL_BITS-1:0] ram_rdata;
  lmbg_pins_t          pins;

  // Handshakes and pipeline advance.
  assign item_i.ready = (state_q == ST_IDLE) && !s1_valid_q;
  assign accept       = item_i.valid && item_i.ready;
  assign out_free     = !out_valid_q || result_o.ready;
  assign s1_move      = s1_valid_q && out_free;
  assign issue        = (state_q == ST_SCAN) && (!s1_valid_q || out_free);

  // Load write: columns beyond the display are ignored.
  assign col_in_x  = WideW'(item_i.column);
  assign ram_we    = accept && (item_i.opcode == OP_LOAD) && (col_in_x < WideW'(COLUMNS));
  assign ram_wdata = {LEVEL_BITS'(item_i.bar_level), LEVEL_BITS'(item_i.peak_level)};

  lmbg_level_ram #(
    .Depth (COLUMNS),
    .Width (2 * LEVEL_BITS)
  ) u_level_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (col_in_x[CntW-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (issue),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  lmbg_pixel_cmp #(
    .LEVEL_BITS (LEVEL_BITS)
  ) u_pixel_cmp (
    .bar_i   (ram_rdata[2*LEVEL_BITS-1:LEVEL_BITS]),
    .peak_i  (ram_rdata[LEVEL_BITS-1:0]),
    .row_i   (row_q),
    .upper_i (upper_q),
    .pins_o  (pins)
  );

  // Row address of a scan: rows count down from the top of each half.
  assign row_in_x  = RowXW'(item_i.row);
  assign upper_in  = row_in_x >= HalfRowsX;
  assign addr_full = (upper_in ? UpperTop : LowerTop) - row_in_x;
  assign s1_col_x  = WideW'(s1_col_q);

  // Next-state logic of the sequencer and the two pipeline stages.
  always_comb begin
    state_d     = state_q;
    col_d       = col_q;
    row_d       = row_q;
    upper_d     = upper_q;
    addr_d      = addr_q;
    s1_valid_d  = s1_valid_q;
    s1_col_d    = s1_col_q;
    out_valid_d = out_valid_q;
    out_addr_d  = out_addr_q;
    out_col_d   = out_col_q;
    out_pins_d  = out_pins_q;
    out_last_d  = out_last_q;

    case (state_q)
      ST_IDLE: begin
        if (accept && (item_i.opcode == OP_SCAN)) begin
          state_d = ST_SCAN;
          col_d   = '0;
          row_d   = item_i.row;
          upper_d = upper_in;
          addr_d  = addr_full[ADDR_W-1:0];
        end
      end
      ST_SCAN: begin
        if (issue) begin
          col_d = col_q + CntW'(1);
          if (col_q == LastCol) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Memory read stage.
    if (issue) begin
      s1_valid_d = 1'b1;
      s1_col_d   = col_q;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end

    // Output register; the row address travels with its column so that a
    // following scan cannot change a result that is still waiting.
    if (s1_move) begin
      out_valid_d = 1'b1;
      out_addr_d  = addr_q;
      out_col_d   = s1_col_x[COL_W-1:0];
      out_pins_d  = pins;
      out_last_d  = (s1_col_q == LastCol);
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      upper_q     <= 1'b0;
      addr_q      <= '0;
      s1_valid_q  <= 1'b0;
      s1_col_q    <= '0;
      out_valid_q <= 1'b0;
      out_addr_q  <= '0;
      out_col_q   <= '0;
      out_pins_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_q       <= col_d;
      row_q       <= row_d;
      upper_q     <= upper_d;
      addr_q      <= addr_d;
      s1_valid_q  <= s1_valid_d;
      s1_col_q    <= s1_col_d;
      out_valid_q <= out_valid_d;
      out_addr_q  <= out_addr_d;
      out_col_q   <= out_col_d;
      out_pins_q  <= out_pins_d;
      out_last_q  <= out_last_d;
    end
  end

  // Result port.
  assign result_o.valid        = out_valid_q;
  assign result_o.row_address  = out_addr_q;
  assign result_o.column_index = out_col_q;
  assign result_o.upper_red    = out_pins_q.upper_red;
  assign result_o.upper_green  = out_pins_q.upper_green;
  assign result_o.lower_red    = out_pins_q.lower_red;
  assign result_o.lower_green  = out_pins_q.lower_green;
  assign result_o.last         = out_last_q;

  // A scan item starts the sequencer at the first column.
  `LMBG_ASSERT_NXT(a_scan_start, clk_i, rst_ni, accept && (item_i.opcode == OP_SCAN), (state_q == ST_SCAN) && (col_q == '0))
  // Reading the final column ends the scan.
  `LMBG_ASSERT_NXT(a_scan_end, clk_i, rst_ni, issue && (col_q == LastCol), state_q == ST_IDLE)
  // The item port stays closed while a column is still in the read stage.
  `LMBG_ASSERT_IMP(a_no_overlap, clk_i, rst_ni, s1_valid_q, !item_i.ready)
  // A stalled read stage keeps its column.
  `LMBG_ASSERT_NXT(a_s1_hold, clk_i, rst_ni, s1_valid_q && !out_free, s1_valid_q && $stable(s1_col_q))

endmodule

// File: tb/sv/tb_led_matrix_bar_graph_scanner.sv
// Self-checking testbench of the LED matrix bar graph scanner: a directed table and random
// load/scan items, each column result checked against a typed expectation or own predictor.
// Depends on lmbg_pkg, the lmbg_item_if/lmbg_result_if interfaces and the scanner RTL.
module tb_led_matrix_bar_graph_scanner;
  timeunit 1ns;
  timeprecision 1ps;

  import lmbg_pkg::*;

  localparam int unsigned DISPLAY_ROWS    = 2 * HALF_ROWS_DEF;
  localparam int unsigned RANDOM_ITEMS    = 274;
  localparam int unsigned SCAN_PERCENT    = 30;
  localparam int unsigned STEADY_FIRST    = 120;
  localparam int unsigned STEADY_LAST     = 180;
  localparam int unsigned PAUSE_AT_ITEM   = 250;
  localparam int unsigned BIG_HOLD_AT     = 1500;
  localparam int unsigned BIG_HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES    = 16;
  localparam int unsigned TIMEOUT_NS      = 20_000_000;

  // Expected pin levels of one column, both halves, active low.
  localparam lmbg_pins_t ALL_DARK      = '1;
  localparam lmbg_pins_t LOWER_RED_LIT = '{upper_red: 1'b1, upper_green: 1'b1,
                                           lower_red: 1'b0, lower_green: 1'b1};
  localparam lmbg_pins_t UPPER_RED_LIT = '{upper_red: 1'b0, upper_green: 1'b1,
                                           lower_red: 1'b1, lower_green: 1'b1};

  // One item transaction, with an optional hand-written expectation for scans.
  typedef struct packed {
    lmbg_op_e              op;
    logic [COL_W-1:0]      column;
    logic [LVL_IN_W-1:0]   bar;
    logic [LVL_IN_W-1:0]   peak;
    logic [ROW_W-1:0]      row;
    logic                  typed;
    logic [ADDR_W-1:0]     exp_addr;
    lmbg_pins_t            exp_pins;
  } stim_row_t;

  // One column result transaction.
  typedef struct packed {
    logic [ADDR_W-1:0] row_address;
    logic [COL_W-1:0]  column_index;
    lmbg_pins_t        pins;
    logic              last;
  } column_result_t;

  localparam int unsigned DIRECTED_ROWS = 22;

  // All columns hold full bars and out-of-range peaks before this table starts.
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{OP_SCAN, 6'd0,  8'd0,   8'd0,   5'd0,  1'b1, 4'd15, LOWER_RED_LIT},
    '{OP_SCAN, 6'd0,  8'd0,   8'd0,   5'd15, 1'b1, 4'd0,  LOWER_RED_LIT},
    '{OP_SCAN, 6'd0,  8'd0,   8'd0,   5'd16, 1'b1, 4'd15, UPPER_RED_LIT},
    '{OP_SCAN, 6'd0,  8'd0,   8'd0,   5'd31, 1'b1, 4'd0,  UPPER_RED_LIT},
    '{OP_LOAD, 6'd0,  8'd0,   8'd0,   5'd0,  1'b0, 4'd0,  ALL_DARK},
    '{OP_LOAD, 6'd63, 8'd255, 8'd0,   5'd31, 1'b0, 4'd0,  ALL_DARK},
    '{OP_LOAD, 6'd1,  8'd1,   8'd1,   5'd0,  1'b0, 4'd0,  ALL_DARK},
    '{OP_LOAD, 6'd2,  8'd16,  8'd17,  5'd0,  1'b0, 4'd0,  ALL_DARK},
    '{OP_LOAD, 6'd3,  8'd32,  8'd32,  5'd0,  1'b0, 4'd0,  ALL_DARK},
    '{OP_LOAD, 6'd4,  8'd31,  8'd31,  5'd0,  1'b0, 4'd0,  ALL_DARK},
    '{OP_LOAD, 6'd5,  8'd0,   8'd255, 5'd0,  1'b0, 4'd0,  ALL_DARK},
    '{OP_LOAD, 6'd6,  8'd20,  8'd16,  5'd0,  1'b0, 4'd0,  ALL_DARK},
    '{OP_LOAD, 6'd42, 8'd170, 8'd85,  5'd0,  1'b0, 4'd0,  ALL_DARK},
    '{OP_LOAD, 6'd21, 8'd85,  8'd170, 5'd0,  1'b0, 4'd0,  ALL_DARK},
    '{OP_SCAN, 6'd63, 8'd255, 8'd255, 5'd0,  1'b0, 4'd0,  ALL_DARK},
    '{OP_SCAN, 6'd0,  8'd0,   8'd0,   5'd15, 1'b0, 4'd0,  ALL_DARK},
    '{OP_SCAN, 6'd0,  8'd0,   8'd0,   5'd16, 1'b0, 4'd0,  ALL_DARK},
    '{OP_SCAN, 6'd0,  8'd0,   8'd0,   5'd31, 1'b0, 4'd0,  ALL_DARK},
    '{OP_SCAN, 6'd0,  8'd0,   8'd0,   5'd1,  1'b0, 4'd0,  ALL_DARK},
    '{OP_SCAN, 6'd0,  8'd0,   8'd0,   5'd30, 1'b0, 4'd0,  ALL_DARK},
    '{OP_SCAN, 6'd0,  8'd0,   8'd0,   5'd10, 1'b0, 4'd0,  ALL_DARK},
    '{OP_SCAN, 6'd0,  8'd0,   8'd0,   5'd21, 1'b0, 4'd0,  ALL_DARK}
  };

  logic clk_i;
  logic rst_ni;

  lmbg_item_if   item_bus ();
  lmbg_result_if result_bus ();

  led_matrix_bar_graph_scanner DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_bus),
    .result_o(result_bus)
  );

  // Shadow copy of the column levels and the queue of columns still to come out.
  logic [LVL_IN_W-1:0] bar_shadow  [COLUMNS_DEF];
  logic [LVL_IN_W-1:0] peak_shadow [COLUMNS_DEF];
  column_result_t      pending_columns [$];

  int unsigned fail_count   = 0;
  int unsigned results_seen = 0;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #TIMEOUT_NS;
    $display("FAIL led_matrix_bar_graph_scanner");
    $finish;
  end

  // Pixel rule of one column for a scanned row: green marks the peak and its row below,
  // red fills the bar, and only the half that holds the row is drawn.
  function automatic column_result_t predict_column(logic [ROW_W-1:0] row, int unsigned col);
    column_result_t res;
    int unsigned    r;
    int unsigned    bar;
    int unsigned    peak;
    logic           upper;
    logic           red_lit;
    logic           green_lit;
    r     = 32'(row);
    bar   = 32'(bar_shadow[col]);
    peak  = 32'(peak_shadow[col]);
    upper = (r >= HALF_ROWS_DEF);
    res.row_address = upper ? ADDR_W'(DISPLAY_ROWS - 1 - r) : ADDR_W'(HALF_ROWS_DEF - 1 - r);
    res.column_index = COL_W'(col);
    // A peak of zero only matches row zero; there is no wrap below it.
    green_lit = (peak == r) || (peak == r + 1);
    red_lit   = (bar > r) && !green_lit;
    res.pins  = ALL_DARK;
    if (upper) begin
      res.pins.upper_red   = !red_lit;
      res.pins.upper_green = !green_lit;
    end else begin
      res.pins.lower_red   = !red_lit;
      res.pins.lower_green = !green_lit;
    end
    res.last = (col == COLUMNS_DEF - 1);
    return res;
  endfunction

  // Update the shadow levels or queue the columns of a scan, once a transaction is accepted.
  // Columns are six bits wide here, so no load falls out of range.
  function automatic void note_accepted(stim_row_t it);
    column_result_t want;
    if (it.op == OP_LOAD) begin
      bar_shadow[it.column]  = it.bar;
      peak_shadow[it.column] = it.peak;
    end else begin
      for (int unsigned k = 0; k < COLUMNS_DEF; k++) begin
        if (it.typed) begin
          want.row_address  = it.exp_addr;
          want.column_index = COL_W'(k);
          want.pins         = it.exp_pins;
          want.last         = (k == COLUMNS_DEF - 1);
        end else begin
          want = predict_column(it.row, k);
        end
        pending_columns.push_back(want);
      end
    end
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned random_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Levels cluster around the row range so that bar edges and peaks land on scanned rows.
  function automatic logic [LVL_IN_W-1:0] random_level();
    if ($urandom_range(0, 3) != 0) return LVL_IN_W'($urandom_range(0, DISPLAY_ROWS + 2));
    return LVL_IN_W'($urandom_range(0, (1 << LVL_IN_W) - 1));
  endfunction

  // Random load or scan; the fields an operation does not use carry noise.
  function automatic stim_row_t random_item();
    stim_row_t it;
    it.column   = COL_W'($urandom_range(0, COLUMNS_DEF - 1));
    it.bar      = random_level();
    it.peak     = random_level();
    it.row      = ROW_W'($urandom_range(0, DISPLAY_ROWS - 1));
    it.typed    = 1'b0;
    it.exp_addr = '0;
    it.exp_pins = ALL_DARK;
    it.op       = ($urandom_range(0, 99) < SCAN_PERCENT) ? OP_SCAN : OP_LOAD;
    return it;
  endfunction

  // Offer one item and wait for its transaction.
  task automatic offer_item(stim_row_t it);
    item_bus.valid      <= 1'b1;
    item_bus.opcode     <= it.op;
    item_bus.column     <= it.column;
    item_bus.bar_level  <= it.bar;
    item_bus.peak_level <= it.peak;
    item_bus.row        <= it.row;
    @(posedge clk_i);
    while (!item_bus.ready) @(posedge clk_i);
    note_accepted(it);
  endtask

  task automatic idle_sender(int unsigned cycles);
    if (cycles != 0) begin
      item_bus.valid <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Report one field of a column result that differs from its expectation.
  function automatic void compare_field(string name, logic [COL_W-1:0] want,
                                        logic [COL_W-1:0] got, logic [COL_W-1:0] col);
    if (got !== want) begin
      fail_count++;
      $display("%0t: column %0d %s expected %0d, got %0d", $realtime, col, name, want, got);
    end
  endfunction

  function automatic void check_column(column_result_t got);
    column_result_t want;
    results_seen++;
    if (pending_columns.size() == 0) begin
      fail_count++;
      $display("%0t: unexpected result, expected none, got %p", $realtime, got);
      return;
    end
    want = pending_columns.pop_front();
    compare_field("row_address", COL_W'(want.row_address), COL_W'(got.row_address),
                  want.column_index);
    compare_field("column_index", want.column_index, got.column_index, want.column_index);
    compare_field("upper_red", COL_W'(want.pins.upper_red), COL_W'(got.pins.upper_red),
                  want.column_index);
    compare_field("upper_green", COL_W'(want.pins.upper_green), COL_W'(got.pins.upper_green),
                  want.column_index);
    compare_field("lower_red", COL_W'(want.pins.lower_red), COL_W'(got.pins.lower_red),
                  want.column_index);
    compare_field("lower_green", COL_W'(want.pins.lower_green), COL_W'(got.pins.lower_green),
                  want.column_index);
    compare_field("last", COL_W'(want.last), COL_W'(got.last), want.column_index);
  endfunction

  // Result side: check each accepted column, then choose ready for the next cycle.
  initial begin
    column_result_t got;
    int unsigned    hold_left;
    int unsigned    cycle_count;
    bit             steady;
    bit             big_hold_done;
    hold_left     = 0;
    cycle_count   = 0;
    steady        = 1'b0;
    big_hold_done = 1'b0;
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && result_bus.valid && result_bus.ready) begin
        got.row_address  = result_bus.row_address;
        got.column_index = result_bus.column_index;
        got.pins         = '{upper_red: result_bus.upper_red,
                             upper_green: result_bus.upper_green,
                             lower_red: result_bus.lower_red,
                             lower_green: result_bus.lower_green};
        got.last         = result_bus.last;
        check_column(got);
      end
      // One long hold-off while the item side keeps offering, so the block backs up.
      if (!big_hold_done && results_seen >= BIG_HOLD_AT) begin
        big_hold_done = 1'b1;
        hold_left     = BIG_HOLD_CYCLES;
      end
      cycle_count++;
      if (cycle_count % 256 == 0) steady = ($urandom_range(0, 2) == 0);
      if (hold_left != 0) begin
        hold_left--;
        result_bus.ready <= 1'b0;
      end else if (steady) begin
        result_bus.ready <= 1'b1;
      end else if ($urandom_range(0, 99) < 2) begin
        hold_left = $urandom_range(10, 40);
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= ($urandom_range(0, 99) < 70);
      end
    end
  end

  // Item side: reset, fill every column, directed table, random transactions, drain.
  initial begin
    stim_row_t   it;
    int unsigned c;
    int unsigned n;
    item_bus.valid      <= 1'b0;
    item_bus.opcode     <= OP_LOAD;
    item_bus.column     <= '0;
    item_bus.bar_level  <= '0;
    item_bus.peak_level <= '0;
    item_bus.row        <= '0;
    rst_ni              <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every column gets written before the first scan reads it.
    for (c = 0; c < COLUMNS_DEF; c++) begin
      it          = '0;
      it.op       = OP_LOAD;
      it.column   = COL_W'(c);
      it.bar      = '1;
      it.peak     = '1;
      it.exp_pins = ALL_DARK;
      offer_item(it);
      idle_sender(random_gap());
    end

    for (n = 0; n < DIRECTED_ROWS; n++) begin
      offer_item(DIRECTED[n]);
      idle_sender(random_gap());
    end

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      // Once, let the block run completely dry before going on.
      if (n == PAUSE_AT_ITEM) begin
        idle_sender(1);
        while (pending_columns.size() != 0) @(posedge clk_i);
      end
      offer_item(random_item());
      if (n < STEADY_FIRST || n >= STEADY_LAST) idle_sender(random_gap());
    end
    item_bus.valid <= 1'b0;

    // Wait for the last columns, then a little longer for anything stray.
    while (pending_columns.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS led_matrix_bar_graph_scanner");
    end else begin
      $display("FAIL led_matrix_bar_graph_scanner");
    end
    $finish;
  end

endmodule
